// ===== rtl/byc_pkg.sv =====
// Shared types and constants of the BGR to YUV 4:2:0 converter.
// Used by the channel interfaces and every module of the block.
`default_nettype none

package byc_pkg;

    localparam int PIX_W = 8;
    localparam int CFG_W = 13;
    localparam int CFG_IDX_W = 1;
    localparam int SUM_W = 18;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [CFG_W-1:0] cfg_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    localparam cfg_idx_t REG_FRAME_WIDTH = 1'd0;
    localparam cfg_idx_t REG_FRAME_HEIGHT = 1'd1;

    localparam cfg_t FRAME_WIDTH_RESET = 13'd320;
    localparam cfg_t FRAME_HEIGHT_RESET = 13'd240;

    localparam sum_t Y_R = 18'sd66;
    localparam sum_t Y_G = 18'sd129;
    localparam sum_t Y_B = 18'sd25;
    localparam sum_t U_R = 18'sd38;
    localparam sum_t U_G = 18'sd74;
    localparam sum_t U_B = 18'sd112;
    localparam sum_t V_R = 18'sd112;
    localparam sum_t V_G = 18'sd94;
    localparam sum_t V_B = 18'sd18;

    localparam pix_t LUMA_BIAS = 8'd16;
    localparam pix_t CHROMA_BIAS = 8'd128;
    localparam int FRAC_BITS = 8;

    typedef struct packed {
        pix_t blue;
        pix_t green;
        pix_t red;
        logic chroma_present;
        logic line_end;
        logic frame_end;
    } byc_item_t;

endpackage

`default_nettype wire

// ===== rtl/byc_pixel_if.sv =====
// Channel interfaces of the converter: BGR pixel in, YUV result out.
// Depends on byc_pkg.
`default_nettype none

interface byc_pixel_if;
    import byc_pkg::*;

    logic valid;
    logic ready;
    pix_t blue;
    pix_t green;
    pix_t red;

    modport source (output valid, output blue, output green, output red, input ready);
    modport sink (input valid, input blue, input green, input red, output ready);
endinterface

interface byc_yuv_if;
    import byc_pkg::*;

    logic valid;
    logic ready;
    pix_t luma;
    pix_t chroma_u;
    pix_t chroma_v;
    logic chroma_present;
    logic line_end;
    logic frame_end;

    modport source (
        output valid, output luma, output chroma_u, output chroma_v,
        output chroma_present, output line_end, output frame_end,
        input ready
    );
    modport sink (
        input valid, input luma, input chroma_u, input chroma_v,
        input chroma_present, input line_end, input frame_end,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/byc_front.sv =====
// Front end: accepts pixels, tracks column and row, tags chroma and line/frame ends.
// Depends on byc_pkg and byc_pixel_if; feeds byc_queue.
`default_nettype none

module byc_front #(
    parameter int MAX_DIMENSION = 4096
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire byc_pkg::cfg_t     frame_width,
    input  wire byc_pkg::cfg_t     frame_height,
    byc_pixel_if.sink              pixel,
    input  wire logic              queue_full,
    output logic                   push,
    output byc_pkg::byc_item_t     push_item
);
    import byc_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
    localparam int SZ_W = (CFG_W > DIM_W) ? CFG_W : DIM_W;
    localparam int POS_W = $clog2(MAX_DIMENSION);
    localparam logic [SZ_W-1:0] TOP_SIZE = SZ_W'(MAX_DIMENSION - (MAX_DIMENSION % 2));
    localparam logic [SZ_W-1:0] MIN_SIZE = SZ_W'(2);

    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic [SZ_W-1:0]  width_even, height_even, eff_width, eff_height;
    logic             chroma, lend, fend;

    always_comb
    begin
        width_even = SZ_W'(frame_width) & ~SZ_W'(1);
        height_even = SZ_W'(frame_height) & ~SZ_W'(1);
        if (width_even < MIN_SIZE)
            eff_width = MIN_SIZE;
        else if (width_even > TOP_SIZE)
            eff_width = TOP_SIZE;
        else
            eff_width = width_even;
        if (height_even < MIN_SIZE)
            eff_height = MIN_SIZE;
        else if (height_even > TOP_SIZE)
            eff_height = TOP_SIZE;
        else
            eff_height = height_even;
    end

    assign chroma = !col_reg[0] && !row_reg[0];
    assign lend = SZ_W'(col_reg) >= (eff_width - SZ_W'(1));
    assign fend = lend && (SZ_W'(row_reg) >= (eff_height - SZ_W'(1)));

    assign pixel.ready = !queue_full;
    assign push = pixel.valid && !queue_full;

    always_comb
    begin
        push_item.blue = pixel.blue;
        push_item.green = pixel.green;
        push_item.red = pixel.red;
        push_item.chroma_present = chroma;
        push_item.line_end = lend;
        push_item.frame_end = fend;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (push)
        begin
            if (lend)
            begin
                col_next = '0;
                row_next = fend ? '0 : row_reg + POS_W'(1);
            end
            else
            begin
                col_next = col_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    a_lend_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        push && lend |=> col_reg == '0)
        else $error("column did not wrap after line end");

    a_fend_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        push && fend |=> row_reg == '0)
        else $error("row did not wrap after frame end");

endmodule

`default_nettype wire

// ===== rtl/byc_queue.sv =====
// Short queue between front and back end of the converter.
// Depends on byc_pkg.
`default_nettype none

module byc_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire byc_pkg::byc_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output byc_pkg::byc_item_t      pop_item,
    output logic                    empty
);
    import byc_pkg::*;

    byc_item_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + QPTR_W'(1);
        return r;
    endfunction

    assign full = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/byc_back.sv =====
// Back end: BT.601 color sums, shift and bias, and the output register.
// Depends on byc_pkg and byc_yuv_if; fed by byc_queue.
`default_nettype none

module byc_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    input  wire byc_pkg::byc_item_t item,
    output logic                    pop,
    byc_yuv_if.source               yuv
);
    import byc_pkg::*;

    logic      s1_valid_reg, s1_valid_next;
    logic      out_valid_reg, out_valid_next;
    logic      out_free, s1_adv;
    sum_t      r_s, g_s, b_s;
    sum_t      y_sum, u_sum, v_sum;
    sum_t      y_sum_reg, u_sum_reg, v_sum_reg;
    byc_item_t s1_item_reg;
    sum_t      y_sh, u_sh, v_sh;
    pix_t      luma_reg, chroma_u_reg, chroma_v_reg;
    logic      chroma_present_reg, line_end_reg, frame_end_reg;

    assign out_free = !out_valid_reg || yuv.ready;
    assign s1_adv = !s1_valid_reg || out_free;
    assign pop = item_valid && s1_adv;

    assign r_s = SUM_W'(item.red);
    assign g_s = SUM_W'(item.green);
    assign b_s = SUM_W'(item.blue);
    assign y_sum = Y_R * r_s + Y_G * g_s + Y_B * b_s;
    assign u_sum = U_B * b_s - U_R * r_s - U_G * g_s;
    assign v_sum = V_R * r_s - V_G * g_s - V_B * b_s;

    assign y_sh = y_sum_reg >>> FRAC_BITS;
    assign u_sh = u_sum_reg >>> FRAC_BITS;
    assign v_sh = v_sum_reg >>> FRAC_BITS;

    always_comb
    begin
        s1_valid_next = s1_adv ? item_valid : s1_valid_reg;
        out_valid_next = out_free ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            y_sum_reg <= y_sum;
            u_sum_reg <= u_sum;
            v_sum_reg <= v_sum;
            s1_item_reg <= item;
        end
        if (out_free && s1_valid_reg)
        begin
            luma_reg <= y_sh[PIX_W-1:0] + LUMA_BIAS;
            chroma_u_reg <= s1_item_reg.chroma_present ?
                            u_sh[PIX_W-1:0] + CHROMA_BIAS : '0;
            chroma_v_reg <= s1_item_reg.chroma_present ?
                            v_sh[PIX_W-1:0] + CHROMA_BIAS : '0;
            chroma_present_reg <= s1_item_reg.chroma_present;
            line_end_reg <= s1_item_reg.line_end;
            frame_end_reg <= s1_item_reg.frame_end;
        end
    end

    assign yuv.valid = out_valid_reg;
    assign yuv.luma = luma_reg;
    assign yuv.chroma_u = chroma_u_reg;
    assign yuv.chroma_v = chroma_v_reg;
    assign yuv.chroma_present = chroma_present_reg;
    assign yuv.line_end = line_end_reg;
    assign yuv.frame_end = frame_end_reg;

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !yuv.ready |=> out_valid_reg && $stable(luma_reg))
        else $error("result changed while stalled");

    a_fend_has_lend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_end_reg |-> line_end_reg)
        else $error("frame end without line end");

endmodule

`default_nettype wire

// ===== rtl/bgr_to_yuv420_converter.sv =====
// BGR to YUV 4:2:0 converter, BT.601 integer coefficients.
// Channels: pixel (sink) takes one blue/green/red pixel per transfer in raster
// order; yuv (source) gives one result per pixel: luma, chroma_u/chroma_v with
// chroma_present at even columns of even rows (else chroma is zero), and
// line_end/frame_end on the last pixel of a line and of the frame.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write frame_width (index 0)
// and frame_height (index 1); write them only while no pixel is in flight.
// Odd sizes round down to even, and sizes clamp to 2..MAX_DIMENSION.
// Each pixel passes the queue, the sum register and the result register in turn.
// Throughput: one pixel per clock while yuv.ready is high, set by the color
// datapath and the two-entry queue between the position tracker and the datapath.
// Reset: sizes return to 320 x 240, column and row to zero, pipeline empties.
// Stall: the result register holds while yuv.ready is low; up to four pixels
// are buffered before pixel.ready drops.
// Depends on byc_pkg, byc_pixel_if, byc_front, byc_queue and byc_back.
`default_nettype none

module bgr_to_yuv420_converter #(
    parameter int MAX_DIMENSION = 4096
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire byc_pkg::cfg_idx_t cfg_index,
    input  wire byc_pkg::cfg_t     cfg_wdata,
    byc_pixel_if.sink              pixel,
    byc_yuv_if.source              yuv
);
    import byc_pkg::*;

    cfg_t      frame_width_reg;
    cfg_t      frame_height_reg;
    logic      push, pop, queue_full, queue_empty;
    byc_item_t push_item, pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg <= cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    byc_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .pixel        (pixel),
        .queue_full   (queue_full),
        .push         (push),
        .push_item    (push_item)
    );

    byc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (queue_empty)
    );

    byc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (!queue_empty),
        .item       (pop_item),
        .pop        (pop),
        .yuv        (yuv)
    );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for bgr_to_yuv420_converter: BGR pixels in, Y/U/V results checked in order.
// A scoreboard class predicts each result from its own copy of sizes and positions.
// Depends on byc_pkg, byc_pixel_if, byc_yuv_if and the converter RTL.

module testbench;
    import byc_pkg::*;

    localparam int MAX_DIM = 4096;

    typedef struct packed {
        pix_t luma;
        pix_t chroma_u;
        pix_t chroma_v;
        logic chroma_present;
        logic line_end;
        logic frame_end;
    } yuv_result_t;

    class bgr_yuv_scoreboard;
        cfg_t width_reg;
        cfg_t height_reg;
        logic [11:0] column;
        logic [11:0] row;
        yuv_result_t pending_yuv[$];
        int errors;
        int checked;

        function new();
            width_reg = FRAME_WIDTH_RESET;
            height_reg = FRAME_HEIGHT_RESET;
            column = '0;
            row = '0;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, cfg_t value);
            if (idx == REG_FRAME_WIDTH)
                width_reg = value;
            else if (idx == REG_FRAME_HEIGHT)
                height_reg = value;
        endfunction

        function int pending();
            return pending_yuv.size();
        endfunction

        function cfg_t effective_size(cfg_t value);
            cfg_t size;
            size = value & ~cfg_t'(1);
            if (size < cfg_t'(2))
                size = cfg_t'(2);
            if (size > cfg_t'(MAX_DIM))
                size = cfg_t'(MAX_DIM);
            return size;
        endfunction

        function pix_t shift_bias(int sum, pix_t bias);
            int shifted;
            shifted = sum >>> FRAC_BITS;
            return pix_t'(shifted + int'(bias));
        endfunction

        function yuv_result_t predict_yuv(pix_t blue, pix_t green, pix_t red);
            yuv_result_t res;
            int b;
            int g;
            int r;
            cfg_t w;
            cfg_t h;
            b = int'(blue);
            g = int'(green);
            r = int'(red);
            w = effective_size(width_reg);
            h = effective_size(height_reg);
            res.chroma_present = !column[0] && !row[0];
            res.line_end = {1'b0, column} >= w - cfg_t'(1);
            res.frame_end = res.line_end && ({1'b0, row} >= h - cfg_t'(1));
            res.luma = shift_bias(66 * r + 129 * g + 25 * b, LUMA_BIAS);
            if (res.chroma_present) begin
                res.chroma_u = shift_bias(-38 * r - 74 * g + 112 * b, CHROMA_BIAS);
                res.chroma_v = shift_bias(112 * r - 94 * g - 18 * b, CHROMA_BIAS);
            end
            else begin
                res.chroma_u = '0;
                res.chroma_v = '0;
            end
            if (res.line_end) begin
                column = '0;
                if (res.frame_end)
                    row = '0;
                else
                    row = row + 12'd1;
            end
            else begin
                column = column + 12'd1;
            end
            return res;
        endfunction

        function void note_pixel(pix_t blue, pix_t green, pix_t red);
            pending_yuv.push_back(predict_yuv(blue, green, red));
        endfunction

        task report_mismatch(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                    checked, name, got, want));
        endtask

        task check_result(yuv_result_t got);
            yuv_result_t want;
            if (pending_yuv.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no pixel pending", checked));
            end
            else begin
                want = pending_yuv.pop_front();
                compare_field("luma", got.luma, want.luma);
                compare_field("chroma_u", got.chroma_u, want.chroma_u);
                compare_field("chroma_v", got.chroma_v, want.chroma_v);
                compare_field("chroma_present", got.chroma_present, want.chroma_present);
                compare_field("line_end", got.line_end, want.line_end);
                compare_field("frame_end", got.frame_end, want.frame_end);
            end
            checked++;
        endtask
    endclass

    localparam logic [23:0] DIRECTED_BGR [0:15] = '{
        24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00,
        24'hFF0000, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
        24'h808080, 24'h7F7F7F, 24'h0100FE, 24'h010203,
        24'hFEFDFC, 24'h10EB80, 24'h123456, 24'h80FF00
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    cfg_idx_t cfg_index;
    cfg_t cfg_wdata;

    byc_pixel_if pixel_ch();
    byc_yuv_if yuv_ch();

    bgr_yuv_scoreboard board;
    int send_idle_pct;
    int recv_stall_pct;
    int random_sent;
    int phase;

    bgr_to_yuv420_converter i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .pixel(pixel_ch.sink),
        .yuv(yuv_ch.source)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (yuv_ch.valid && yuv_ch.ready)
                board.check_result({yuv_ch.luma, yuv_ch.chroma_u, yuv_ch.chroma_v,
                    yuv_ch.chroma_present, yuv_ch.line_end, yuv_ch.frame_end});
            yuv_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 57; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 57; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
        endcase
    endtask

    task automatic send_pixel(pix_t blue, pix_t green, pix_t red);
        if ($urandom_range(99) < send_idle_pct) begin
            pixel_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        pixel_ch.valid <= 1'b1;
        pixel_ch.blue <= blue;
        pixel_ch.green <= green;
        pixel_ch.red <= red;
        @(posedge clk);
        while (!pixel_ch.ready)
            @(posedge clk);
        board.note_pixel(blue, green, red);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        pixel_ch.valid <= 1'b0;
        while (board.pending() != 0 && guard < 5000) begin
            @(posedge clk);
            guard++;
        end
    endtask

    task automatic write_sizes(cfg_t width, cfg_t height);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_wdata <= width;
        @(posedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_wdata <= height;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.write_reg(REG_FRAME_WIDTH, width);
        board.write_reg(REG_FRAME_HEIGHT, height);
    endtask

    function automatic pix_t random_component();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return pix_t'($urandom_range(255));
        endcase
    endfunction

    function automatic cfg_t random_size();
        case ($urandom_range(9))
            7: return cfg_t'($urandom_range(13, 64));
            8: begin
                case ($urandom_range(3))
                    0: return cfg_t'(4095);
                    1: return cfg_t'(4096);
                    2: return cfg_t'(4097);
                    default: return cfg_t'(8191);
                endcase
            end
            9: return cfg_t'($urandom_range(8191));
            default: return cfg_t'($urandom_range(12));
        endcase
    endfunction

    initial
    begin
        int count;
        board = new();
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_wdata = '0;
        pixel_ch.valid = 1'b0;
        pixel_ch.blue = '0;
        pixel_ch.green = '0;
        pixel_ch.red = '0;
        yuv_ch.ready = 1'b0;
        set_idling(0);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 16; i++)
            send_pixel(DIRECTED_BGR[i][23:16], DIRECTED_BGR[i][15:8], DIRECTED_BGR[i][7:0]);
        drain();
        write_sizes(cfg_t'(1), cfg_t'(0));
        for (int i = 0; i < 6; i++)
            send_pixel(DIRECTED_BGR[i + 6][23:16], DIRECTED_BGR[i + 6][15:8],
                DIRECTED_BGR[i + 6][7:0]);
        drain();
        write_sizes(cfg_t'(8191), cfg_t'(4097));
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd0);
        drain();
        write_sizes(cfg_t'(3), cfg_t'(2));

        random_sent = 0;
        phase = 0;
        while (random_sent < 1600) begin
            set_idling(phase);
            count = $urandom_range(20, 120);
            for (int i = 0; i < count; i++)
                send_pixel(random_component(), random_component(), random_component());
            random_sent += count;
            phase++;
            drain();
            write_sizes(random_size(), random_size());
        end

        drain();
        if (board.pending() != 0)
            board.report_mismatch($sformatf("%0d results never arrived", board.pending()));
        repeat (10) @(posedge clk);
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
